// ===== rtl/ptmi_pkg.sv =====
// ============================================================================
// ptmi_pkg - shared types and helpers for the page table map installer
// Field widths, entry layout, state encoding and register indexes used by the
// installer core and its port checker.
// ============================================================================
package ptmi_pkg;

    // Default number of 4 KiB tables in the table store
    localparam int TABLES_DEF = 16;

    // Field widths
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int ROOT_W    = 4;
    localparam int FRAME_W   = 40;
    localparam int FFT_W     = 5;
    localparam int ENTRY_W   = 64;
    localparam int IDX_W     = 9;
    localparam int LVL_W     = 2;
    localparam int TADD_W    = 2;

    // Stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAME_W;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

    // Walk levels
    localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep the whole store to zero after reset
        ST_IDLE,    // wait for a request
        ST_READ,    // issue the read of one upper entry
        ST_CHECK,   // inspect the entry read
        ST_ZERO,    // clear a freshly allocated table
        ST_LINK,    // point the current entry at the new table
        ST_LEAF,    // write the leaf entry
        ST_DONE     // hand the result to the output register
    } t_state;

    // Pick the 9-bit table index of a level out of the virtual address
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0]  va,
                                                     input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    // Build a present, writable entry for a frame, with optional user bit
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                      input logic               user);
        return {12'd0, frame, 9'd0, user, 1'b1, 1'b1};
    endfunction

endpackage

// ===== rtl/ptmi_ram.sv =====
// ============================================================================
// ptmi_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module ptmi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/page_table_map_installer_core.sv =====
// ============================================================================
// page_table_map_installer_core - four-level page table mapping installer
// Walks a PML4/PDPT/PD/PT hierarchy held in an internal table store and
// installs one 4 KiB mapping per request, allocating missing tables.
// ============================================================================
// Usage:
//   Requests arrive on the s_axis channel, one transaction per mapping; each
//   produces exactly one result transaction on m_axis (status, tables added).
//   Configuration (store base frame, first free table) is written through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata while no request is in flight;
//   writing the first free table also reloads the allocator.
// Operation:
//   The store is one RAM with a registered read, so each upper level
//   passes through a read state and a check state. A refused root goes
//   straight to the result. A table is allocated by clearing it, one
//   entry per cycle through the RAM write port, and then linking it; no
//   read is made below the first missing level, and a request that
//   allocates tables allocates from 1 to 3 of them.
//   One request is worked on at a time.
// Reset:
//   i_rst_n (synchronous, active low) starts a clearing pass that writes zero
//   to all TABLES*512 entries, one per cycle; s_axis_tready stays low until it
//   ends. Configuration writes are taken during the pass.
// Stall:
//   The result sits in an output register; a new request is accepted while it
//   waits, and the next result waits in ST_DONE until the register is free.
// ============================================================================
module page_table_map_installer_core #(
    parameter int TABLES = ptmi_pkg::TABLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Requests: [47:0] virt_addr, [99:48] phys_addr, [103:100] root_index,
    //           [104] user_access, [111:105] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ptmi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Results: [0] status, [2:1] tables_added, [7:3] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ptmi_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [ptmi_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [ptmi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import ptmi_pkg::*;

    localparam int TW    = $clog2(TABLES);
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = TABLES * (2 ** IDX_W);
    localparam int NFW0  = $clog2(TABLES + 1);
    localparam int NFW   = (NFW0 > FFT_W) ? NFW0 : FFT_W;
    localparam int CW    = NFW + 1;

    // Request fields
    logic [VA_W-1:0]    s_va;
    logic [FRAME_W-1:0] s_pa_frame;
    logic [ROOT_W-1:0]  s_root;
    logic               s_user;

    assign s_va       = s_axis_tdata[47:0];
    assign s_pa_frame = s_axis_tdata[99:60];
    assign s_root     = s_axis_tdata[103:100];
    assign s_user     = s_axis_tdata[104];

    // Registers
    t_state             r_state,    n_state;
    logic [AW-1:0]      r_cnt,      n_cnt;
    logic [FRAME_W-1:0] r_base,     n_base;
    logic [NFW-1:0]     r_next,     n_next;
    logic [VA_W-1:0]    r_va,       n_va;
    logic [FRAME_W-1:0] r_pa_frame, n_pa_frame;
    logic               r_user,     n_user;
    logic [TW-1:0]      r_cur,      n_cur;
    logic [LVL_W-1:0]   r_lvl,      n_lvl;
    logic [TADD_W-1:0]  r_need,     n_need;
    logic               r_fail,     n_fail;
    logic               r_m_tvalid, n_m_tvalid;
    logic               r_status,   n_status;
    logic [TADD_W-1:0]  r_tables,   n_tables;

    // RAM interface
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Entry inspection
    logic               rd_present;
    logic [FRAME_W-1:0] rd_rel;
    logic               rd_in_store;
    logic [TADD_W-1:0]  miss_need;
    logic               alloc_fits;
    logic               root_ok;
    logic               s_take;

    ptmi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode the entry read and the allocator headroom
    assign rd_present  = ram_rdata[0];
    assign rd_rel      = ram_rdata[51:12] - r_base;
    assign rd_in_store = (rd_rel < FRAME_W'(TABLES));
    assign miss_need   = 2'd3 - r_lvl;
    assign alloc_fits  = ({1'b0, r_next} + CW'(miss_need)) <= CW'(TABLES);
    assign root_ok     = (32'(s_root) < 32'(TABLES));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_take        = s_axis_tvalid && s_axis_tready;

    // Read address: one upper entry of the current table
    assign ram_re    = (r_state == ST_READ);
    assign ram_raddr = {r_cur, level_index(r_va, r_lvl)};

    // Write port mux
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_ZERO: begin
                ram_we    = 1'b1;
                ram_waddr = {r_next[TW-1:0], r_cnt[IDX_W-1:0]};
            end
            ST_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = {r_cur, level_index(r_va, r_lvl)};
                ram_wdata = make_entry(r_base + FRAME_W'(r_next), r_user);
            end
            ST_LEAF: begin
                ram_we    = 1'b1;
                ram_waddr = {r_cur, level_index(r_va, LVL_PT)};
                ram_wdata = make_entry(r_pa_frame, r_user);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next state and datapath
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_base     = r_base;
        n_next     = r_next;
        n_va       = r_va;
        n_pa_frame = r_pa_frame;
        n_user     = r_user;
        n_cur      = r_cur;
        n_lvl      = r_lvl;
        n_need     = r_need;
        n_fail     = r_fail;
        n_status   = r_status;
        n_tables   = r_tables;
        n_m_tvalid = r_m_tvalid && !m_axis_tready;

        case (r_state)
            // Sweep the store to zero
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            // Latch a request; refuse a root outside the store at once
            ST_IDLE: begin
                if (s_take) begin
                    n_va       = s_va;
                    n_pa_frame = s_pa_frame;
                    n_user     = s_user;
                    n_cur      = TW'(s_root);
                    n_lvl      = LVL_PML4;
                    n_need     = '0;
                    n_fail     = !root_ok;
                    n_state    = root_ok ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            // Follow a present entry, or plan allocation from here down
            ST_CHECK: begin
                if (!rd_present) begin
                    n_need = miss_need;
                    n_cnt  = '0;
                    if (alloc_fits) begin
                        n_state = ST_ZERO;
                    end else begin
                        n_fail  = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (!rd_in_store) begin
                    n_fail  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_cur = rd_rel[TW-1:0];
                    if (r_lvl == LVL_PD) begin
                        n_state = ST_LEAF;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            // Clear the table being allocated
            ST_ZERO: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[IDX_W-1:0] == {IDX_W{1'b1}}) begin
                    n_state = ST_LINK;
                end
            end
            // Link it in and advance the allocator
            ST_LINK: begin
                n_cur  = r_next[TW-1:0];
                n_next = r_next + 1'b1;
                n_cnt  = '0;
                if (r_lvl == LVL_PD) begin
                    n_state = ST_LEAF;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = ST_ZERO;
                end
            end
            ST_LEAF: begin
                n_state = ST_DONE;
            end
            // Load the result once the output register is free
            ST_DONE: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_status   = r_fail;
                    n_tables   = r_fail ? '0 : r_need;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STORE_BASE: n_base = i_cfg_wdata;
                CFG_FIRST_FREE: n_next = NFW'(i_cfg_wdata[FFT_W-1:0]);
                default:        n_base = r_base;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_base     <= '0;
            r_next     <= NFW'(1);
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_base     <= n_base;
            r_next     <= n_next;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_va       <= n_va;
        r_pa_frame <= n_pa_frame;
        r_user     <= n_user;
        r_cur      <= n_cur;
        r_lvl      <= n_lvl;
        r_need     <= n_need;
        r_fail     <= n_fail;
        r_status   <= n_status;
        r_tables   <= n_tables;
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {{(M_TDATA_W - TADD_W - 1){1'b0}}, r_tables, r_status};

endmodule

// ===== rtl/ptmi_checker.sv =====
// ============================================================================
// ptmi_checker - port-level checks for the page table map installer
// Watches the stream ports of the core and is bound to every instance.
// ============================================================================
module ptmi_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [ptmi_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ptmi_pkg::*;

    // Reset starts the clearing pass with nothing accepted or offered
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request or result channel active right after reset");

    // One request at a time: an accepted transaction closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again while a request is in flight");

    // A refused request reports no allocated tables
    a_refused_no_tables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[TADD_W:1] == '0)
        else $error("refused request reports allocated tables");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

endmodule

bind page_table_map_installer_core ptmi_checker u_ptmi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
